// ===== src/array_insert_delete_search_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the ordered word store checks.
// ----------------------------------------------------------------------------
`ifndef ARRAY_INSERT_DELETE_SEARCH_MACROS_SVH
`define ARRAY_INSERT_DELETE_SEARCH_MACROS_SVH

// same-cycle implication, disabled while in reset
`define AIDS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define AIDS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/aids_pkg.sv =====
// ----------------------------------------------------------------------------
// aids_pkg
// Types, codes and sizes shared by the ordered word store.
// ----------------------------------------------------------------------------
package aids_pkg;

    localparam int CAPACITY  = 32;
    localparam int IDX_W     = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);

    localparam int CMD_W     = 3;
    localparam int POS_W     = 6;
    localparam int WORD_W    = 32;
    localparam int ST_W      = 3;
    localparam int CNT_OUT_W = 6;

    localparam int CMP_W     = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    localparam int S_DATA_W  = ((POS_W + WORD_W + 7) / 8) * 8;
    localparam int M_DATA_W  = ((POS_W + WORD_W + CNT_OUT_W + 7) / 8) * 8;

    localparam logic [CMD_W-1:0] CMD_APPEND   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_DELETE   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SEARCH   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_TRAVERSE = 3'd4;

    localparam logic [ST_W-1:0] ST_OK       = 3'd0;
    localparam logic [ST_W-1:0] ST_FULL     = 3'd1;
    localparam logic [ST_W-1:0] ST_BADPOS   = 3'd2;
    localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd3;
    localparam logic [ST_W-1:0] ST_EMPTY    = 3'd4;

    typedef struct packed {
        logic load;       // capture accepted request
        logic update;     // single-result command: modify store and emit
        logic compare;    // register search match vector
        logic srch_out;   // emit search result
        logic walk_out;   // emit one traverse word
    } t_dp_cmd;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             count_zero;
        logic             out_free;
        logic             walk_last;
    } t_dp_stat;

endpackage

// ===== src/aids_ctrl.sv =====
// ----------------------------------------------------------------------------
// aids_ctrl
// Sequencer for the ordered word store: accept, execute, search, traverse.
// ----------------------------------------------------------------------------
module aids_ctrl
    import aids_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_s_tvalid,
    output logic     o_s_tready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_SRCH = 2'd2;
    localparam logic [1:0] S_WALK = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state    = r_state;
        o_s_tready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                priority if (i_stat.cmd == CMD_SEARCH) begin
                    o_cmd.compare = 1'b1;
                    n_state       = S_SRCH;
                end else if (i_stat.cmd == CMD_TRAVERSE && !i_stat.count_zero) begin
                    n_state = S_WALK;
                end else if (i_stat.out_free) begin
                    o_cmd.update = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    n_state = S_EXEC;
                end
            end
            S_SRCH: begin
                if (i_stat.out_free) begin
                    o_cmd.srch_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_WALK: begin
                if (i_stat.out_free) begin
                    o_cmd.walk_out = 1'b1;
                    if (i_stat.walk_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== src/aids_dp.sv =====
// ----------------------------------------------------------------------------
// aids_dp
// Word registers, count, match vector, traverse cursor and output register.
// ----------------------------------------------------------------------------
module aids_dp
    import aids_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    output t_dp_stat            o_stat,
    input  logic [CMD_W-1:0]    i_req_cmd,
    input  logic [POS_W-1:0]    i_req_pos,
    input  logic [WORD_W-1:0]   i_req_item,
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output logic [ST_W-1:0]     o_status,
    output logic [POS_W-1:0]    o_found_pos,
    output logic [WORD_W-1:0]   o_value,
    output logic [CNT_OUT_W-1:0] o_count,
    output logic                o_last
);

    logic [CMD_W-1:0]         r_cmd;
    logic [POS_W-1:0]         r_pos;
    logic signed [WORD_W-1:0] r_item;

    logic [WORD_W-1:0] r_words [CAPACITY];
    logic [WORD_W-1:0] n_words [CAPACITY];
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic [ST_W-1:0]   n_status;
    logic [CAPACITY-1:0] r_match;
    logic [IDX_W-1:0]  r_walk;

    logic [CMP_W-1:0]  w_pos;
    logic [CMP_W-1:0]  w_pos_m1;
    logic [CMP_W-1:0]  w_cnt;
    logic              w_full;
    logic              w_hit;
    logic [CNT_W-1:0]  w_at;
    logic              w_walk_last;

    logic                 r_m_valid;
    logic [ST_W-1:0]      r_status;
    logic [POS_W-1:0]     r_found_pos;
    logic [WORD_W-1:0]    r_value;
    logic [CNT_OUT_W-1:0] r_count_out;
    logic                 r_last;

    assign w_pos       = CMP_W'(r_pos);
    assign w_pos_m1    = w_pos - CMP_W'(1);
    assign w_cnt       = CMP_W'(r_count);
    assign w_full      = (w_cnt >= CMP_W'(CAPACITY));
    assign w_walk_last = ((CNT_W'(r_walk) + CNT_W'(1)) == r_count);

    assign o_stat.cmd        = r_cmd;
    assign o_stat.count_zero = (r_count == '0);
    assign o_stat.out_free   = !r_m_valid || i_m_tready;
    assign o_stat.walk_last  = w_walk_last;

    // single-result commands: status and next store contents
    always_comb begin
        n_words  = r_words;
        n_count  = r_count;
        n_status = ST_OK;
        unique case (r_cmd)
            CMD_APPEND: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_words[r_count[IDX_W-1:0]] = r_item;
                    n_count = r_count + CNT_W'(1);
                end
            end
            CMD_INSERT: begin
                priority if (w_full) begin
                    n_status = ST_FULL;
                end else if (w_pos == '0 || w_pos > w_cnt + CMP_W'(1)) begin
                    n_status = ST_BADPOS;
                end else begin
                    for (int i = 1; i < CAPACITY; i++) begin
                        if (CMP_W'(i) > w_pos_m1) begin
                            n_words[i] = r_words[i-1];
                        end
                    end
                    n_words[w_pos_m1[IDX_W-1:0]] = r_item;
                    n_count = r_count + CNT_W'(1);
                end
            end
            CMD_DELETE: begin
                priority if (r_count == '0) begin
                    n_status = ST_EMPTY;
                end else if (w_pos == '0 || w_pos > w_cnt) begin
                    n_status = ST_BADPOS;
                end else begin
                    for (int i = 0; i < CAPACITY - 1; i++) begin
                        if (CMP_W'(i) >= w_pos_m1) begin
                            n_words[i] = r_words[i+1];
                        end
                    end
                    n_count = r_count - CNT_W'(1);
                end
            end
            CMD_TRAVERSE: begin
                n_status = ST_EMPTY;
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    // first match, lowest position wins
    always_comb begin
        w_hit = 1'b0;
        w_at  = '0;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (r_match[i]) begin
                w_hit = 1'b1;
                w_at  = CNT_W'(i + 1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd  <= i_req_cmd;
            r_pos  <= i_req_pos;
            r_item <= i_req_item;
        end
        if (i_cmd.update) begin
            r_words <= n_words;
        end
        if (i_cmd.compare) begin
            for (int i = 0; i < CAPACITY; i++) begin
                r_match[i] <= (r_words[i] == r_item) && (CNT_W'(i) < r_count);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_walk  <= '0;
        end else begin
            if (i_cmd.update) begin
                r_count <= n_count;
            end
            if (i_cmd.walk_out) begin
                r_walk <= w_walk_last ? '0 : r_walk + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (i_cmd.update || i_cmd.srch_out || i_cmd.walk_out) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_status    <= n_status;
            r_found_pos <= '0;
            r_value     <= '0;
            r_count_out <= CNT_OUT_W'(n_count);
            r_last      <= 1'b1;
        end else if (i_cmd.srch_out) begin
            r_status    <= w_hit ? ST_OK : ST_NOTFOUND;
            r_found_pos <= POS_W'(w_at);
            r_value     <= '0;
            r_count_out <= CNT_OUT_W'(r_count);
            r_last      <= 1'b1;
        end else if (i_cmd.walk_out) begin
            r_status    <= ST_OK;
            r_found_pos <= POS_W'(r_walk) + POS_W'(1);
            r_value     <= r_words[r_walk];
            r_count_out <= CNT_OUT_W'(r_count);
            r_last      <= w_walk_last;
        end
    end

    assign o_m_tvalid  = r_m_valid;
    assign o_status    = r_status;
    assign o_found_pos = r_found_pos;
    assign o_value     = r_value;
    assign o_count     = r_count_out;
    assign o_last      = r_last;

endmodule

// ===== src/array_insert_delete_search.sv =====
// A request is captured when accepted; append, insert, delete, unused commands
// and a traverse of an empty store then write the output register; search first
// registers the match vector, then priority-encodes it; traverse gives one word a
// cycle. Results wait while the output stalls; no request is taken while busy.
// Reset (synchronous, active low) clears count, traverse cursor, sequencer and
// output valid; word registers are not reset.
// ----------------------------------------------------------------------------
// array_insert_delete_search
// Ordered store of signed words with append, insert, delete, search, traverse.
// ----------------------------------------------------------------------------
module array_insert_delete_search
    import aids_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  logic [S_DATA_W-1:0] i_s_tdata,  // position[5:0], item[37:6], zero pad
    input  logic [CMD_W-1:0]    i_s_tuser,  // cmd[2:0]
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output logic [M_DATA_W-1:0] o_m_tdata,  // found_position[5:0], value[37:6],
                                            // count[43:38], zero pad
    output logic [ST_W-1:0]     o_m_tuser,  // status[2:0]
    output logic                o_m_tlast
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    logic [POS_W-1:0]     w_found_pos;
    logic [WORD_W-1:0]    w_value;
    logic [CNT_OUT_W-1:0] w_count;

    aids_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    aids_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_req_cmd   (i_s_tuser),
        .i_req_pos   (i_s_tdata[POS_W-1:0]),
        .i_req_item  (i_s_tdata[POS_W+WORD_W-1:POS_W]),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_status    (o_m_tuser),
        .o_found_pos (w_found_pos),
        .o_value     (w_value),
        .o_count     (w_count),
        .o_last      (o_m_tlast)
    );

    assign o_m_tdata = M_DATA_W'({w_count, w_value, w_found_pos});

endmodule

// ===== src/aids_checker.sv =====
// ----------------------------------------------------------------------------
// aids_checker
// Port-level checks for the ordered word store, bound to the top level.
// ----------------------------------------------------------------------------
`include "array_insert_delete_search_macros.svh"

module aids_checker
    import aids_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_s_tvalid,
    input logic                o_s_tready,
    input logic                o_m_tvalid,
    input logic                i_m_tready,
    input logic [M_DATA_W-1:0] o_m_tdata,
    input logic [ST_W-1:0]     o_m_tuser,
    input logic                o_m_tlast
);

    logic                        w_s_acc;
    logic                        w_stall;
    logic                        w_err;
    logic [M_DATA_W+ST_W:0]      w_reply;
    logic [CNT_OUT_W-1:0]        w_cnt_out;
    logic [POS_W+WORD_W-1:0]     w_low;

    assign w_s_acc   = i_s_tvalid && o_s_tready;
    assign w_stall   = o_m_tvalid && !i_m_tready;
    assign w_err     = o_m_tvalid && (o_m_tuser != ST_OK);
    assign w_reply   = {o_m_tdata, o_m_tuser, o_m_tlast};
    assign w_cnt_out = o_m_tdata[POS_W+WORD_W+CNT_OUT_W-1:POS_W+WORD_W];
    assign w_low     = o_m_tdata[POS_W+WORD_W-1:0];

    `AIDS_ASSERT_NEXT(a_stall_hold, w_stall, o_m_tvalid && $stable(w_reply), "result changed in stall")

    `AIDS_ASSERT_NEXT(a_busy_after_req, w_s_acc, !o_s_tready, "ready while request in work")

    `AIDS_ASSERT_NOW(a_count_bound, o_m_tvalid, w_cnt_out <= CNT_OUT_W'(CAPACITY), "count too high")

    `AIDS_ASSERT_NOW(a_error_single, w_err, o_m_tlast && w_low == '0, "error result not single or clear")

endmodule

bind array_insert_delete_search aids_checker u_aids_checker (.*);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives command requests into the ordered word store and checks every reply.
// A directed table covers empty, bad-position, extreme-word and unused-command
// cases, then random phases grow the store to full, drain it to empty and mix
// commands. Replies are checked field by field against a local store image.
// ----------------------------------------------------------------------------
module tb;
    import aids_pkg::*;

    localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_C = 3'd7;

    localparam int RANDOM_REQUESTS = 385;
    localparam int STALL_LIMIT     = 2000;
    localparam int DIRECTED_LEN    = 26;

    typedef struct packed {
        logic [ST_W-1:0]          status;
        logic [POS_W-1:0]         found_pos;
        logic signed [WORD_W-1:0] value;
        logic [CNT_OUT_W-1:0]     count;
        logic                     last;
    } store_reply_t;

    typedef struct packed {
        logic [CMD_W-1:0]         cmd;
        logic [POS_W-1:0]         pos;
        logic signed [WORD_W-1:0] item;
        logic                     typed;
        store_reply_t             reply;
    } directed_row_t;

    typedef enum {PH_GROW, PH_SHRINK, PH_MIXED, PH_NOISE} phase_t;

    // typed replies only where the outcome is obvious; the rest use the store image
    localparam directed_row_t DIRECTED_ROWS [DIRECTED_LEN] = '{
        '{CMD_TRAVERSE, 6'd0,  32'sh0,        1'b1, '{ST_EMPTY,    6'd0, 32'sh0, 6'd0, 1'b1}},
        '{CMD_DELETE,   6'd1,  32'sh0,        1'b1, '{ST_EMPTY,    6'd0, 32'sh0, 6'd0, 1'b1}},
        '{CMD_SEARCH,   6'd0,  32'sh5,        1'b1, '{ST_NOTFOUND, 6'd0, 32'sh0, 6'd0, 1'b1}},
        '{CMD_INSERT,   6'd0,  32'sh9,        1'b1, '{ST_BADPOS,   6'd0, 32'sh0, 6'd0, 1'b1}},
        '{CMD_INSERT,   6'd2,  32'sh9,        1'b1, '{ST_BADPOS,   6'd0, 32'sh0, 6'd0, 1'b1}},
        '{CMD_INSERT,   6'd1,  32'sh7fffffff, 1'b1, '{ST_OK,       6'd0, 32'sh0, 6'd1, 1'b1}},
        '{CMD_APPEND,   6'd0,  32'sh80000000, 1'b1, '{ST_OK,       6'd0, 32'sh0, 6'd2, 1'b1}},
        '{CMD_APPEND,   6'd0,  32'shffffffff, 1'b1, '{ST_OK,       6'd0, 32'sh0, 6'd3, 1'b1}},
        '{CMD_INSERT,   6'd4,  32'sh0,        1'b0, '0},
        '{CMD_INSERT,   6'd2,  32'sh55555555, 1'b0, '0},
        '{CMD_INSERT,   6'd63, 32'sh1,        1'b1, '{ST_BADPOS,   6'd0, 32'sh0, 6'd5, 1'b1}},
        '{CMD_INSERT,   6'd7,  32'sh1,        1'b1, '{ST_BADPOS,   6'd0, 32'sh0, 6'd5, 1'b1}},
        '{CMD_DELETE,   6'd0,  32'sh0,        1'b1, '{ST_BADPOS,   6'd0, 32'sh0, 6'd5, 1'b1}},
        '{CMD_DELETE,   6'd6,  32'sh0,        1'b1, '{ST_BADPOS,   6'd0, 32'sh0, 6'd5, 1'b1}},
        '{CMD_DELETE,   6'd40, 32'sh0,        1'b1, '{ST_BADPOS,   6'd0, 32'sh0, 6'd5, 1'b1}},
        '{CMD_SEARCH,   6'd0,  32'sh80000000, 1'b0, '0},
        '{CMD_SEARCH,   6'd0,  32'sh2aaaaaaa, 1'b0, '0},
        '{CMD_TRAVERSE, 6'd0,  32'sh0,        1'b0, '0},
        '{CMD_SPARE_A,  6'd63, 32'shffffffff, 1'b1, '{ST_OK,       6'd0, 32'sh0, 6'd5, 1'b1}},
        '{CMD_SPARE_B,  6'd21, 32'sh55555555, 1'b1, '{ST_OK,       6'd0, 32'sh0, 6'd5, 1'b1}},
        '{CMD_SPARE_C,  6'd42, 32'sh2aaaaaaa, 1'b1, '{ST_OK,       6'd0, 32'sh0, 6'd5, 1'b1}},
        '{CMD_DELETE,   6'd5,  32'sh0,        1'b0, '0},
        '{CMD_DELETE,   6'd1,  32'sh0,        1'b0, '0},
        '{CMD_APPEND,   6'd0,  32'sh55555555, 1'b0, '0},
        '{CMD_SEARCH,   6'd0,  32'sh55555555, 1'b0, '0},
        '{CMD_TRAVERSE, 6'd0,  32'sh0,        1'b0, '0}
    };

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;   // position[5:0], item[37:6], zero pad
    logic [CMD_W-1:0]    s_tuser = '0;   // cmd[2:0]
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;        // found_position[5:0], value[37:6], count[43:38]
    logic [ST_W-1:0]     m_tuser;        // status[2:0]
    logic                m_tlast;

    logic signed [WORD_W-1:0] shadow_words [CAPACITY];
    int                       shadow_count = 0;
    store_reply_t             replies_due [$];
    int                       fault_count = 0;
    int                       burst_left = 0;

    array_insert_delete_search dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .o_m_tlast  (m_tlast)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic void push_reply(logic [ST_W-1:0] st, int fpos,
                                       logic signed [WORD_W-1:0] val, logic last);
        store_reply_t r;
        r.status    = st;
        r.found_pos = fpos[POS_W-1:0];
        r.value     = val;
        r.count     = shadow_count[CNT_OUT_W-1:0];
        r.last      = last;
        replies_due.push_back(r);
    endfunction

    function automatic void predict_store_replies(logic [CMD_W-1:0] cmd,
                                                  logic [POS_W-1:0] pos,
                                                  logic signed [WORD_W-1:0] item);
        int p;
        int at;
        p  = int'(pos);
        at = 0;
        case (cmd)
            CMD_APPEND: begin
                if (shadow_count >= CAPACITY) begin
                    push_reply(ST_FULL, 0, '0, 1'b1);
                end else begin
                    shadow_words[shadow_count] = item;
                    shadow_count++;
                    push_reply(ST_OK, 0, '0, 1'b1);
                end
            end
            CMD_INSERT: begin
                // full takes priority over a bad position
                if (shadow_count >= CAPACITY) begin
                    push_reply(ST_FULL, 0, '0, 1'b1);
                end else if (p < 1 || p > shadow_count + 1) begin
                    push_reply(ST_BADPOS, 0, '0, 1'b1);
                end else begin
                    for (int i = shadow_count; i >= p; i--)
                        shadow_words[i] = shadow_words[i-1];
                    shadow_words[p-1] = item;
                    shadow_count++;
                    push_reply(ST_OK, 0, '0, 1'b1);
                end
            end
            CMD_DELETE: begin
                if (shadow_count == 0) begin
                    push_reply(ST_EMPTY, 0, '0, 1'b1);
                end else if (p < 1 || p > shadow_count) begin
                    push_reply(ST_BADPOS, 0, '0, 1'b1);
                end else begin
                    for (int i = p - 1; i + 1 < shadow_count; i++)
                        shadow_words[i] = shadow_words[i+1];
                    shadow_count--;
                    push_reply(ST_OK, 0, '0, 1'b1);
                end
            end
            CMD_SEARCH: begin
                for (int i = shadow_count - 1; i >= 0; i--)
                    if (shadow_words[i] == item) at = i + 1;
                push_reply((at != 0) ? ST_OK : ST_NOTFOUND, at, '0, 1'b1);
            end
            CMD_TRAVERSE: begin
                if (shadow_count == 0) begin
                    push_reply(ST_EMPTY, 0, '0, 1'b1);
                end else begin
                    for (int i = 0; i < shadow_count; i++)
                        push_reply(ST_OK, i + 1, shadow_words[i], i + 1 == shadow_count);
                end
            end
            default: push_reply(ST_OK, 0, '0, 1'b1);
        endcase
    endfunction

    function automatic void compare_field(string name, logic [WORD_W-1:0] want,
                                          logic [WORD_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            fault_count++;
        end
    endfunction

    // reply checker
    always @(posedge clk) begin
        store_reply_t got;
        store_reply_t want;
        if (rst_n && m_tvalid && m_tready) begin
            got.status    = m_tuser;
            got.found_pos = m_tdata[5:0];
            got.value     = m_tdata[37:6];
            got.count     = m_tdata[43:38];
            got.last      = m_tlast;
            if (replies_due.size() == 0) begin
                $display("%0t: unexpected reply, expected none, actual %h", $time, got);
                fault_count++;
            end else begin
                want = replies_due.pop_front();
                compare_field("status", want.status, got.status);
                compare_field("found_position", want.found_pos, got.found_pos);
                compare_field("value", want.value, got.value);
                compare_field("count", want.count, got.count);
                compare_field("last", want.last, got.last);
            end
        end
    end

    // receiver back-pressure, one pattern per span
    initial begin : reply_stall
        int mode;
        int span;
        forever begin
            mode = $urandom_range(3, 0);
            span = $urandom_range(64, 16);
            for (int tick = 0; tick < span; tick++) begin
                @(posedge clk);
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(1, 0));
                    2:       m_tready <= ($urandom_range(3, 0) == 0);
                    default: m_tready <= (tick % 3 == 0);
                endcase
            end
        end
    end

    // ends the run if no handshake happens on either side for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
            else quiet++;
        end
        $display("array_insert_delete_search verification failed");
        $finish;
    end

    task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                                input logic signed [WORD_W-1:0] item);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {{(S_DATA_W - POS_W - WORD_W){1'b0}}, item, pos};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        predict_store_replies(cmd, pos, item);
    endtask

    task automatic pace_sender();
        int gap;
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(20, 1);
            gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 1);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic drain_replies();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (replies_due.size() > 0);
    endtask

    function automatic logic signed [WORD_W-1:0] pick_word();
        int roll;
        roll = $urandom_range(99, 0);
        if (roll < 30) return $signed($urandom_range(7, 0)) - 4;
        if (roll < 35) return 32'sh7fffffff;
        if (roll < 40) return 32'sh80000000;
        return $urandom;
    endfunction

    task automatic pick_request(input phase_t kind, output logic [CMD_W-1:0] cmd,
                                output logic [POS_W-1:0] pos,
                                output logic signed [WORD_W-1:0] item);
        int roll;
        roll = $urandom_range(99, 0);
        item = pick_word();
        pos  = POS_W'($urandom_range(63, 0));
        cmd  = CMD_W'($urandom_range(7, 0));
        if (kind == PH_NOISE) roll = 100 + roll;
        case (kind)
            PH_GROW: begin
                if (roll < 45)      cmd = CMD_APPEND;
                else if (roll < 80) cmd = CMD_INSERT;
                else if (roll < 88) cmd = CMD_SEARCH;
                else if (roll < 94) cmd = CMD_TRAVERSE;
            end
            PH_SHRINK: begin
                if (roll < 60)      cmd = CMD_DELETE;
                else if (roll < 75) cmd = CMD_SEARCH;
                else if (roll < 82) cmd = CMD_TRAVERSE;
                else if (roll < 90) cmd = CMD_APPEND;
            end
            PH_MIXED: begin
                if (roll < 25)      cmd = CMD_APPEND;
                else if (roll < 45) cmd = CMD_INSERT;
                else if (roll < 70) cmd = CMD_DELETE;
                else if (roll < 90) cmd = CMD_SEARCH;
                else if (roll < 95) cmd = CMD_TRAVERSE;
            end
            default: ;
        endcase
        // well-formed positions and frequent search hits unless this is a noise request
        if (roll < 100) begin
            if (cmd == CMD_INSERT) pos = POS_W'($urandom_range(shadow_count + 1, 1));
            if (cmd == CMD_DELETE && shadow_count > 0)
                pos = POS_W'($urandom_range(shadow_count, 1));
            if (cmd == CMD_SEARCH && shadow_count > 0 && $urandom_range(9, 0) < 6)
                item = shadow_words[$urandom_range(shadow_count - 1, 0)];
        end
    endtask

    initial begin : stimulus
        logic [CMD_W-1:0]         cmd;
        logic [POS_W-1:0]         pos;
        logic signed [WORD_W-1:0] item;
        phase_t                   kind;
        int                       sent;
        int                       phase_idx;
        int                       span;
        int                       at_limit_left;
        bit                       at_limit;
        bit                       done;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED_ROWS[r]) begin
            send_request(DIRECTED_ROWS[r].cmd, DIRECTED_ROWS[r].pos, DIRECTED_ROWS[r].item);
            if (DIRECTED_ROWS[r].typed)
                replies_due[replies_due.size() - 1] = DIRECTED_ROWS[r].reply;
            pace_sender();
        end
        drain_replies();

        // first two phases force full and empty stores
        sent = 0;
        phase_idx = 0;
        while (sent < RANDOM_REQUESTS) begin
            if (phase_idx == 0)      kind = PH_GROW;
            else if (phase_idx == 1) kind = PH_SHRINK;
            else                     kind = phase_t'($urandom_range(3, 0));
            span = $urandom_range(40, 15);
            at_limit_left = 4;
            done = 1'b0;
            for (int n = 0; !done; n++) begin
                pick_request(kind, cmd, pos, item);
                at_limit = (kind == PH_GROW && shadow_count == CAPACITY) ||
                           (kind == PH_SHRINK && shadow_count == 0);
                send_request(cmd, pos, item);
                pace_sender();
                sent++;
                if (at_limit) at_limit_left--;
                if (kind == PH_GROW || kind == PH_SHRINK)
                    done = (at_limit_left == 0) || (n >= 150);
                else
                    done = (n + 1 >= span);
                if (sent >= RANDOM_REQUESTS) done = 1'b1;
            end
            if (phase_idx == 1 || $urandom_range(2, 0) == 0) drain_replies();
            phase_idx++;
        end

        drain_replies();
        repeat (8) @(posedge clk);
        if (replies_due.size() != 0) begin
            $display("%0t: %0d replies never arrived", $time, replies_due.size());
            fault_count++;
        end
        if (fault_count == 0)
            $display("array_insert_delete_search verification clean");
        else
            $display("array_insert_delete_search verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+src
src/aids_pkg.sv
src/aids_ctrl.sv
src/aids_dp.sv
src/array_insert_delete_search.sv
src/aids_checker.sv
tb/tb.sv
